// ----- design/smd_pkg.sv -----
// shared constants and codes for the sorted merge and dedup core
package smd_pkg;

  localparam int LIST_DEPTH  = 16;
  localparam int MAX_RESULTS = 32;
  localparam int WORD_W      = 32;
  localparam int MODE_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
  localparam int ADDR_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

  localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MERGE  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_VALUE = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd3;

endpackage

// ----- design/smd_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
module smd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ----- design/sorted_merge_dedup_core.sv -----
// Sorted merge and dedup core: words are appended one per transaction to list A or
// list B, each held in its own ram of LIST_DEPTH words. A load or clear transaction
// gives one result. A merge transaction walks both lists in signed order, one head
// decision per cycle while the output is not stalled, each step consuming the smaller
// head or both equal heads (at most count_a + count_b steps), then a final step
// delivers the held word; the single registered read port of each list ram sets that pace.
// Each distinct word, up to MAX_RESULTS, is delivered once, with last set on the final
// result of every transaction. Output stall holds the walk without losing any word.
module sorted_merge_dedup_core
  import smd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [MODE_W-1:0]          in_mode,
  input  logic signed [WORD_W-1:0]   in_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [STATUS_W-1:0]        out_status,
  output logic signed [WORD_W-1:0]   out_merged_value,
  output logic                       out_last
);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_MERGE = 1'b1;

  logic                  state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_a_r, cnt_a_nxt;
  logic [CNT_W-1:0]      cnt_b_r, cnt_b_nxt;
  logic [CNT_W-1:0]      ia_r, ia_nxt;
  logic [CNT_W-1:0]      ib_r, ib_nxt;
  logic [NRES_W-1:0]     nres_r, nres_nxt;
  logic                  have_prev_r, have_prev_nxt;
  logic [WORD_W-1:0]     prev_r, prev_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [WORD_W-1:0]     out_value_r, out_value_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  out_free;
  logic                  in_accept;
  logic                  we_a, we_b;
  logic [WORD_W-1:0]     rd_a, rd_b;
  logic                  a_has, b_has;
  logic [WORD_W-1:0]     pick;
  logic                  emit;
  logic                  full_a, full_b;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) && out_free);
  assign in_accept = in_valid && !in_stall;

  assign full_a = (cnt_a_r >= CNT_W'(LIST_DEPTH));
  assign full_b = (cnt_b_r >= CNT_W'(LIST_DEPTH));
  assign we_a   = in_accept && (in_mode == MODE_LOAD_A) && !full_a;
  assign we_b   = in_accept && (in_mode == MODE_LOAD_B) && !full_b;

  smd_ram #(.WIDTH(WORD_W), .DEPTH(LIST_DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (cnt_a_r[ADDR_W-1:0]),
    .wdata (in_value),
    .raddr (ia_nxt[ADDR_W-1:0]),
    .rdata (rd_a)
  );

  smd_ram #(.WIDTH(WORD_W), .DEPTH(LIST_DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (cnt_b_r[ADDR_W-1:0]),
    .wdata (in_value),
    .raddr (ib_nxt[ADDR_W-1:0]),
    .rdata (rd_b)
  );

  assign a_has = (ia_r < cnt_a_r);
  assign b_has = (ib_r < cnt_b_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_a_nxt     = cnt_a_r;
    cnt_b_nxt     = cnt_b_r;
    ia_nxt        = ia_r;
    ib_nxt        = ib_r;
    nres_nxt      = nres_r;
    have_prev_nxt = have_prev_r;
    prev_nxt      = prev_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    pick          = rd_a;
    emit          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        ia_nxt = '0;
        ib_nxt = '0;
        if (in_accept) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          out_value_nxt  = '0;
          out_last_nxt   = 1'b1;
          case (in_mode)
            MODE_LOAD_A: begin
              if (full_a) out_status_nxt = STAT_FULL;
              else        cnt_a_nxt = cnt_a_r + 1'b1;
            end
            MODE_LOAD_B: begin
              if (full_b) out_status_nxt = STAT_FULL;
              else        cnt_b_nxt = cnt_b_r + 1'b1;
            end
            MODE_MERGE: begin
              if ((cnt_a_r == '0) && (cnt_b_r == '0)) begin
                out_status_nxt = STAT_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                state_nxt     = S_MERGE;
                nres_nxt      = '0;
                have_prev_nxt = 1'b0;
              end
            end
            default: begin
              cnt_a_nxt = '0;
              cnt_b_nxt = '0;
            end
          endcase
        end
      end
      S_MERGE: begin
        if (out_free) begin
          if (!a_has && !b_has) begin
            // flush the held word as the final result
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_VALUE;
            out_value_nxt  = prev_r;
            out_last_nxt   = 1'b1;
            state_nxt      = S_IDLE;
            ia_nxt         = '0;
            ib_nxt         = '0;
          end else begin
            if (a_has && b_has) begin
              if ($signed(rd_a) < $signed(rd_b)) begin
                pick   = rd_a;
                ia_nxt = ia_r + 1'b1;
              end else if ($signed(rd_b) < $signed(rd_a)) begin
                pick   = rd_b;
                ib_nxt = ib_r + 1'b1;
              end else begin
                pick   = rd_a;
                ia_nxt = ia_r + 1'b1;
                ib_nxt = ib_r + 1'b1;
              end
            end else if (a_has) begin
              pick   = rd_a;
              ia_nxt = ia_r + 1'b1;
            end else begin
              pick   = rd_b;
              ib_nxt = ib_r + 1'b1;
            end
            emit = (nres_r < NRES_W'(MAX_RESULTS)) && !(have_prev_r && (prev_r == pick));
            if (emit) begin
              // the previously held word is now known not to be the last
              if (have_prev_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_VALUE;
                out_value_nxt  = prev_r;
                out_last_nxt   = 1'b0;
              end
              prev_nxt      = pick;
              have_prev_nxt = 1'b1;
              nres_nxt      = nres_r + 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      ia_r        <= '0;
      ib_r        <= '0;
      nres_r      <= '0;
      have_prev_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      ia_r        <= ia_nxt;
      ib_r        <= ib_nxt;
      nres_r      <= nres_nxt;
      have_prev_r <= have_prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r       <= prev_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_merged_value = out_value_r;
  assign out_last         = out_last_r;

endmodule

// ----- design/smd_checker.sv -----
// port-level checks for the sorted merge and dedup core, bound to the top level
module smd_checker
  import smd_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic [MODE_W-1:0]        in_mode,
  input logic signed [WORD_W-1:0] in_value,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [STATUS_W-1:0]      out_status,
  input logic signed [WORD_W-1:0] out_merged_value,
  input logic                     out_last
);

  // no result pending right after reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_merged_value) && $stable(out_last))
    else $error("stalled result changed");

  // status-only results carry zero and close their transaction
  a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_VALUE) |-> (out_merged_value == '0) && out_last)
    else $error("status result malformed");

  // a new transaction is taken only once the previous one has delivered its last result
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !out_valid || out_last)
    else $error("input taken during a merge");

endmodule

bind sorted_merge_dedup_core smd_checker u_smd_checker (.*);

// ----- sim/sorted_merge_dedup_checker.sv -----
`timescale 1ns / 100ps
// scoreboard for the sorted merge and dedup core: list predictor and result compare
module sorted_merge_dedup_checker
  import smd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [MODE_W-1:0]        in_mode,
  input  logic signed [WORD_W-1:0] in_value,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [STATUS_W-1:0]      out_status,
  input  logic signed [WORD_W-1:0] out_merged_value,
  input  logic                     out_last,
  output int                       fail_count,
  output int                       pending
);

  typedef struct {
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] word;
    logic                     last;
  } merge_result_t;

  logic signed [WORD_W-1:0] list_a [LIST_DEPTH];
  logic signed [WORD_W-1:0] list_b [LIST_DEPTH];
  int count_a = 0;
  int count_b = 0;
  int mismatch_count = 0;
  merge_result_t predicted_results [$];

  task automatic log_failure(input string msg);
    if (mismatch_count < 10) begin
      $display("%s", msg);
    end
    mismatch_count++;
  endtask

  task automatic predict_merge();
    int ia;
    int ib;
    logic signed [WORD_W-1:0] pick;
    logic signed [WORD_W-1:0] distinct [$];
    merge_result_t r;
    ia = 0;
    ib = 0;
    if (count_a == 0 && count_b == 0) begin
      r.status = STAT_EMPTY;
      r.word = '0;
      r.last = 1'b1;
      predicted_results.push_back(r);
    end else begin
      while (ia < count_a || ib < count_b) begin
        if (ia < count_a && (ib >= count_b || list_a[ia] < list_b[ib])) begin
          pick = list_a[ia];
          ia++;
        end else if (ib < count_b && (ia >= count_a || list_b[ib] < list_a[ia])) begin
          pick = list_b[ib];
          ib++;
        end else begin
          pick = list_a[ia];
          ia++;
          ib++;
        end
        if (distinct.size() < MAX_RESULTS &&
            (distinct.size() == 0 || distinct[$] != pick)) begin
          distinct.push_back(pick);
        end
      end
      foreach (distinct[i]) begin
        r.status = STAT_VALUE;
        r.word = distinct[i];
        r.last = (i == distinct.size() - 1);
        predicted_results.push_back(r);
      end
    end
  endtask

  task automatic predict_item(input logic [MODE_W-1:0] mode,
                              input logic signed [WORD_W-1:0] value);
    merge_result_t r;
    r.status = STAT_OK;
    r.word = '0;
    r.last = 1'b1;
    if (mode == MODE_MERGE) begin
      predict_merge();
    end else begin
      case (mode)
        MODE_LOAD_A: begin
          if (count_a >= LIST_DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            list_a[count_a] = value;
            count_a++;
          end
        end
        MODE_LOAD_B: begin
          if (count_b >= LIST_DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            list_b[count_b] = value;
            count_b++;
          end
        end
        default: begin
          count_a = 0;
          count_b = 0;
        end
      endcase
      predicted_results.push_back(r);
    end
  endtask

  always @(posedge clk) begin : watch
    merge_result_t head;
    if (!rst_n) begin
      count_a = 0;
      count_b = 0;
      predicted_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          log_failure($sformatf("unexpected result: status %0d value %0d last %0b",
                                out_status, out_merged_value, out_last));
        end else begin
          head = predicted_results.pop_front();
          if (head.status !== out_status || head.word !== out_merged_value ||
              head.last !== out_last) begin
            log_failure($sformatf({"result mismatch: expected status %0d value %0d last %0b,",
                                   " got status %0d value %0d last %0b"},
                                  head.status, head.word, head.last,
                                  out_status, out_merged_value, out_last));
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_item(in_mode, in_value);
      end
    end
    pending <= predicted_results.size();
    fail_count <= mismatch_count;
  end

endmodule

// ----- sim/sorted_merge_dedup_core_tb.sv -----
`timescale 1ns / 100ps
// stimulus, clock and verdict for the sorted merge and dedup core
module sorted_merge_dedup_core_tb;
  import smd_pkg::*;

  localparam int ITEM_TARGET  = 360;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 60;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam longint WORD_MAX_L = 64'sd2147483647;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [MODE_W-1:0]        in_mode;
  logic signed [WORD_W-1:0] in_value;
  logic                     out_valid;
  logic                     out_stall;
  logic [STATUS_W-1:0]      out_status;
  logic signed [WORD_W-1:0] out_merged_value;
  logic                     out_last;
  logic                     hold_request;
  int                       fail_count;
  int                       pending;
  int                       items_sent;
  int                       steady_left;
  int                       cycle_count;

  sorted_merge_dedup_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_merged_value (out_merged_value),
    .out_last         (out_last)
  );

  sorted_merge_dedup_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_merged_value (out_merged_value),
    .out_last         (out_last),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic send_item(input logic [MODE_W-1:0] mode,
                           input logic signed [WORD_W-1:0] value);
    int gap;
    int pick;
    in_valid <= 1'b1;
    in_mode <= mode;
    in_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (steady_left > 0) begin
      gap = 0;
      steady_left--;
    end else begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        steady_left = $urandom_range(10, 40);
        gap = 0;
      end else if (pick < 10) begin
        gap = 0;
      end else if (pick < 18) begin
        gap = $urandom_range(1, 3);
      end else begin
        gap = $urandom_range(5, 30);
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 6);
    if (r < 9) return $urandom_range(7, LIST_DEPTH);
    return $urandom_range(LIST_DEPTH + 1, LIST_DEPTH + 3);
  endfunction

  function automatic longint advance(input longint cur, input bit wide, input bit ordered);
    longint nxt;
    if (!ordered) begin
      nxt = wide ? longint'($signed($urandom)) : longint'($urandom_range(0, 24)) - 12;
    end else begin
      nxt = cur + (wide ? longint'($urandom_range(0, 32'h1000_0000))
                        : longint'($urandom_range(0, 3)));
    end
    if (nxt > WORD_MAX_L) nxt = WORD_MAX_L;
    return nxt;
  endfunction

  // both lists start from a common base so equal heads show up often
  task automatic load_lists();
    int len_a;
    int len_b;
    int sent_a;
    int sent_b;
    bit wide;
    bit ordered;
    longint base;
    longint next_a;
    longint next_b;
    len_a = pick_length();
    len_b = pick_length();
    wide = ($urandom_range(0, 3) == 0);
    ordered = ($urandom_range(0, 9) != 0);
    base = wide ? -64'sd2147483648 + longint'($urandom_range(0, 32'h0400_0000))
                : longint'($urandom_range(0, 16)) - 12;
    next_a = advance(base, wide, ordered);
    next_b = advance(base, wide, ordered);
    sent_a = 0;
    sent_b = 0;
    while (sent_a < len_a || sent_b < len_b) begin
      if (sent_b >= len_b || (sent_a < len_a && $urandom_range(0, 1) == 0)) begin
        send_item(MODE_LOAD_A, WORD_W'(next_a));
        next_a = advance(next_a, wide, ordered);
        sent_a++;
      end else begin
        send_item(MODE_LOAD_B, WORD_W'(next_b));
        next_b = advance(next_b, wide, ordered);
        sent_b++;
      end
    end
  endtask

  initial begin : drain_side
    int run;
    int pick;
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        pick = $urandom_range(0, 19);
        if (pick < 8) begin
          out_stall <= 1'b0;
          run = $urandom_range(1, 40);
        end else if (pick < 18) begin
          out_stall <= 1'b1;
          run = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          run = $urandom_range(10, 40);
        end
        repeat (run) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sorted_merge_dedup_core verification failed");
    $finish;
  end

  initial begin : stimulus
    int kind;
    items_sent = 0;
    steady_left = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_mode <= MODE_LOAD_A;
    in_value <= '0;
    hold_request <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty merge, extremes, equal heads, adjacent duplicates, full list, clear
    send_item(MODE_MERGE, '0);
    send_item(MODE_LOAD_A, WORD_MIN);
    send_item(MODE_LOAD_A, -32'sd1);
    send_item(MODE_LOAD_A, WORD_MAX);
    send_item(MODE_LOAD_B, WORD_MIN);
    send_item(MODE_LOAD_B, '0);
    send_item(MODE_LOAD_B, '0);
    send_item(MODE_LOAD_B, WORD_MAX);
    send_item(MODE_MERGE, '0);
    for (int i = 0; i < LIST_DEPTH - 3; i++) begin
      send_item(MODE_LOAD_A, (i % 2) ? 32'h5555_5555 - i : 32'hAAAA_AAAA + i);
    end
    send_item(MODE_LOAD_A, 32'sd42);
    send_item(MODE_MERGE, $urandom);
    send_item(MODE_CLEAR, $urandom);

    hold_request <= 1'b1;
    while (items_sent < ITEM_TARGET) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        if ($urandom_range(0, 4) != 0) send_item(MODE_CLEAR, $urandom);
        load_lists();
        send_item(MODE_MERGE, $urandom);
        if ($urandom_range(0, 5) == 0) send_item(MODE_MERGE, $urandom);
      end else begin
        repeat ($urandom_range(1, 6)) send_item(MODE_W'($urandom_range(0, 3)), $urandom);
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("sorted_merge_dedup_core verification clean");
    end else begin
      $display("sorted_merge_dedup_core verification failed");
    end
    $finish;
  end

endmodule
